// ===== rtl/gtpm_pkg.sv =====
// Shared types and constants for the gyro-to-pointer motion block.
// Used by the top level, the shared multiply-accumulate unit and the port checker.
`default_nettype none

package gtpm_pkg;

    // Fixed formats of the rate, residue and step words
    localparam int FRAC_BITS  = 8;    // fractional bits of the sub-pixel residue
    localparam int STEP_LIMIT = 127;  // largest step magnitude per beat
    localparam int RATE_W     = 20;
    localparam int RES_W      = 24;
    localparam int STEP_W     = 8;

    // Register formats
    localparam int WEIGHT_W   = 9;
    localparam int DZ_W       = 16;
    localparam int GAIN_W     = 12;
    localparam int WEIGHT_ONE = 256;  // weight and gain are Q.8
    localparam int ROUND_BITS = 8;

    // Configuration channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier: rate operand times weight/gain operand
    localparam int MUL_B_W    = 13;
    localparam int ACC_W      = RATE_W + MUL_B_W;

    // Stream widths
    localparam int S_TDATA_W  = 2 * RATE_W;
    localparam int M_TDATA_W  = 2 * STEP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT   = 2'd0,
        CFG_DEADZONE = 2'd1,
        CFG_GAIN     = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_NEW,
        ST_P_OLD,
        ST_Y_NEW,
        ST_Y_OLD,
        ST_Y_WRITE,
        ST_GAIN_X,
        ST_GAIN_Y,
        ST_RES_Y,
        ST_STEP
    } seq_state_t;

    // Control of the multiply-accumulate unit
    typedef struct packed {
        logic en;    // update the accumulator this cycle
        logic load;  // 1: acc = product, 0: acc += product
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/gtpm_mac.sv =====
// Shared signed multiply-accumulate unit for the EMA and gain products.
// Depends on gtpm_pkg for widths and the control struct.
`default_nettype none

module gtpm_mac (
    input  wire logic                                aclk,
    input  wire gtpm_pkg::mac_ctrl_t                 ctrl,
    input  wire logic signed [gtpm_pkg::RATE_W-1:0]  op_a,
    input  wire logic signed [gtpm_pkg::MUL_B_W-1:0] op_b,
    output logic signed [gtpm_pkg::ACC_W-1:0]        acc
);
    import gtpm_pkg::*;

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    // One product per cycle while ctrl.en is set, either loaded or added
    assign prod     = ACC_W'(op_a) * ACC_W'(op_b);
    assign acc_next = ctrl.load ? prod : acc_reg + prod;

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/gyro_to_pointer_motion_unit.sv =====
// Gyro rate to pointer step block: EMA per axis, deadzone, gain, sub-pixel residue.
// m_tvalid rises as ST_STEP completes for a taken input beat, if the step is nonzero.
// A new sample is taken only in the idle state, after all nine sequencer states, six of
// them products through the one shared multiplier; a result still waiting holds the step.
// Reset (aresetn low, synchronous) restores the register defaults and clears filters and
// residues; no clearing pass is needed.
// Depends on gtpm_pkg and gtpm_mac.
`default_nettype none

module gyro_to_pointer_motion_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [gtpm_pkg::S_TDATA_W-1:0]        s_tdata,  // [19:0] pitch_rate, [39:20] yaw_rate
    input  wire logic                                  s_tuser,  // [0] restart
    // result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [gtpm_pkg::M_TDATA_W-1:0]             m_tdata,  // [7:0] move_x, [15:8] move_y
    // configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [gtpm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gtpm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import gtpm_pkg::*;

    localparam logic signed [ACC_W-1:0] RATE_HI  = ACC_W'(2**(RATE_W-1) - 1);
    localparam logic signed [ACC_W-1:0] RATE_LO  = ACC_W'(-(2**(RATE_W-1)));
    localparam logic signed [ACC_W-1:0] RES_HI   = ACC_W'(2**(RES_W-1) - 1);
    localparam logic signed [ACC_W-1:0] RES_LO   = ACC_W'(-(2**(RES_W-1)));
    localparam int                      ROUND_HALF = 2**(ROUND_BITS-1);
    localparam int                      FRAC_MASK  = 2**FRAC_BITS - 1;

    // round to nearest, halves up, dropping the Q.8 scale
    function automatic logic signed [ACC_W-1:0] round_q8(input logic signed [ACC_W-1:0] v);
        return (v + ACC_W'(ROUND_HALF)) >>> ROUND_BITS;
    endfunction

    function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [ACC_W-1:0] v);
        if (v > RATE_HI) return RATE_W'(RATE_HI);
        if (v < RATE_LO) return RATE_W'(RATE_LO);
        return RATE_W'(v);
    endfunction

    function automatic logic signed [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] v);
        if (v > RES_HI) return RES_W'(RES_HI);
        if (v < RES_LO) return RES_W'(RES_LO);
        return RES_W'(v);
    endfunction

    // whole pixels, truncated toward zero, clamped
    function automatic logic signed [STEP_W-1:0] step_of(input logic signed [RES_W-1:0] r);
        logic signed [RES_W:0] bias;
        logic signed [RES_W:0] q;
        bias = r[RES_W-1] ? (RES_W+1)'(FRAC_MASK) : (RES_W+1)'(0);
        q    = ((RES_W+1)'(r) + bias) >>> FRAC_BITS;
        if (q > (RES_W+1)'(STEP_LIMIT))  return STEP_W'(STEP_LIMIT);
        if (q < (RES_W+1)'(-STEP_LIMIT)) return STEP_W'(-STEP_LIMIT);
        return STEP_W'(q);
    endfunction

    seq_state_t state_reg, state_next;

    logic [WEIGHT_W-1:0]       weight_reg;
    logic [DZ_W-1:0]           dz_reg;
    logic signed [GAIN_W-1:0]  gain_reg;

    logic signed [RATE_W-1:0]  pitch_in_reg, yaw_in_reg;
    logic signed [RATE_W-1:0]  sp_reg, sy_reg;
    logic signed [RES_W-1:0]   rx_reg, ry_reg;
    logic signed [STEP_W-1:0]  mx_reg, my_reg;
    logic                      out_valid_reg;

    mac_ctrl_t                 mac_ctrl;
    logic signed [RATE_W-1:0]  op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [ACC_W-1:0]   acc;
    logic                      gate_b;
    logic                      wr_sp, wr_sy, wr_rx, wr_ry, do_step;

    logic [WEIGHT_W-1:0]       w_eff;
    logic signed [MUL_B_W-1:0] w_new, w_old, gain_b;
    logic signed [RATE_W:0]    a_ext;
    logic [RATE_W:0]           a_mag;
    logic                      dz_pass;
    logic signed [RATE_W-1:0]  ema_val;
    logic signed [RES_W-1:0]   rx_sum, ry_sum;
    logic signed [STEP_W-1:0]  mx, my;
    logic                      step_nz, can_load, s_accept;

    // Operand preparation
    assign w_eff  = (weight_reg > WEIGHT_W'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : weight_reg;
    assign w_new  = MUL_B_W'(w_eff);
    assign w_old  = MUL_B_W'(WEIGHT_ONE) - w_new;
    assign gain_b = MUL_B_W'(gain_reg);

    // Deadzone compare on the multiplier's rate operand, shared by both axes
    assign a_ext   = (RATE_W+1)'(op_a);
    assign a_mag   = op_a[RATE_W-1] ? (RATE_W+1)'(-a_ext) : (RATE_W+1)'(a_ext);
    assign dz_pass = a_mag > (RATE_W+1)'(dz_reg);

    // Results taken from the accumulator
    assign ema_val = sat_rate(round_q8(acc));
    assign rx_sum  = sat_res(ACC_W'(rx_reg) + round_q8(acc));
    assign ry_sum  = sat_res(ACC_W'(ry_reg) + round_q8(acc));

    assign mx       = step_of(rx_reg);
    assign my       = step_of(ry_reg);
    assign step_nz  = (mx != '0) || (my != '0);
    assign can_load = !out_valid_reg || m_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    gtpm_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_accept) state_next = ST_P_NEW;
            ST_P_NEW:   state_next = ST_P_OLD;
            ST_P_OLD:   state_next = ST_Y_NEW;
            ST_Y_NEW:   state_next = ST_Y_OLD;
            ST_Y_OLD:   state_next = ST_Y_WRITE;
            ST_Y_WRITE: state_next = ST_GAIN_X;
            ST_GAIN_X:  state_next = ST_GAIN_Y;
            ST_GAIN_Y:  state_next = ST_RES_Y;
            ST_RES_Y:   state_next = ST_STEP;
            ST_STEP:    if (can_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer: operand selection and write strobes
    always_comb begin
        mac_ctrl = '{en: 1'b0, load: 1'b0};
        op_a     = sp_reg;
        gate_b   = 1'b0;
        op_b     = w_new;
        wr_sp    = 1'b0;
        wr_sy    = 1'b0;
        wr_rx    = 1'b0;
        wr_ry    = 1'b0;
        do_step  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_P_NEW: begin
                mac_ctrl = '{en: 1'b1, load: 1'b1};
                op_a     = pitch_in_reg;
                op_b     = w_new;
            end
            ST_P_OLD: begin
                mac_ctrl = '{en: 1'b1, load: 1'b0};
                op_a     = sp_reg;
                op_b     = w_old;
            end
            ST_Y_NEW: begin
                wr_sp    = 1'b1;
                mac_ctrl = '{en: 1'b1, load: 1'b1};
                op_a     = yaw_in_reg;
                op_b     = w_new;
            end
            ST_Y_OLD: begin
                mac_ctrl = '{en: 1'b1, load: 1'b0};
                op_a     = sy_reg;
                op_b     = w_old;
            end
            ST_Y_WRITE: begin
                wr_sy = 1'b1;
            end
            ST_GAIN_X: begin
                mac_ctrl = '{en: 1'b1, load: 1'b1};
                op_a     = sy_reg;
                gate_b   = 1'b1;
            end
            ST_GAIN_Y: begin
                wr_rx    = 1'b1;
                mac_ctrl = '{en: 1'b1, load: 1'b1};
                op_a     = sp_reg;
                gate_b   = 1'b1;
            end
            ST_RES_Y: begin
                wr_ry = 1'b1;
            end
            ST_STEP: begin
                do_step = can_load;
            end
            default: begin
            end
        endcase
        // inside the deadzone the increment is forced to zero
        if (gate_b) begin
            op_b = dz_pass ? gain_b : '0;
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            weight_reg    <= WEIGHT_W'(77);
            dz_reg        <= DZ_W'(51);
            gain_reg      <= GAIN_W'(-256);
        end else begin
            state_reg <= state_next;
            if (do_step && step_nz) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_WEIGHT:   weight_reg <= cfg_data[WEIGHT_W-1:0];
                    CFG_DEADZONE: dz_reg     <= cfg_data[DZ_W-1:0];
                    CFG_GAIN:     gain_reg   <= cfg_data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Filter and residue state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
            sy_reg <= '0;
            rx_reg <= '0;
            ry_reg <= '0;
        end else if (s_accept && s_tuser) begin
            sp_reg <= '0;
            sy_reg <= '0;
            rx_reg <= '0;
            ry_reg <= '0;
        end else begin
            if (wr_sp) sp_reg <= ema_val;
            if (wr_sy) sy_reg <= ema_val;
            if (wr_rx) rx_reg <= rx_sum;
            if (wr_ry) ry_reg <= ry_sum;
            // keep only the fraction and any clamped excess
            if (do_step && step_nz) begin
                rx_reg <= rx_reg - (RES_W'(mx) <<< FRAC_BITS);
                ry_reg <= ry_reg - (RES_W'(my) <<< FRAC_BITS);
            end
        end
    end

    // Input capture and output register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pitch_in_reg <= s_tdata[RATE_W-1:0];
            yaw_in_reg   <= s_tdata[2*RATE_W-1:RATE_W];
        end
        if (do_step && step_nz) begin
            mx_reg <= mx;
            my_reg <= my;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {my_reg, mx_reg};

endmodule

`default_nettype wire

// ===== rtl/gtpm_checker.sv =====
// Port-level checks for gyro_to_pointer_motion_unit, attached by bind.
// Depends on gtpm_pkg for port widths and the step width.
`default_nettype none

module gtpm_checker (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_tvalid,
    input wire logic                                  s_tready,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [gtpm_pkg::M_TDATA_W-1:0]        m_tdata
);
    import gtpm_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a beat is only sent when some step is nonzero
    a_out_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[STEP_W-1:0] != '0) || (m_tdata[M_TDATA_W-1:STEP_W] != '0))
        else $error("result beat with both steps zero");

    // steps stay inside the clamp, so the most negative code never shows
    a_out_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[STEP_W-1:0] != {1'b1, {(STEP_W-1){1'b0}}})
                  && (m_tdata[M_TDATA_W-1:STEP_W] != {1'b1, {(STEP_W-1){1'b0}}}))
        else $error("step outside the clamp range");

    // the sequencer is busy in the cycle after taking a sample
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while still working");

endmodule

bind gyro_to_pointer_motion_unit gtpm_checker u_gtpm_checker (.*);

`default_nettype wire
